/* rtl/adsr_pkg.sv */
// types, constants and microcode table of the linear adsr envelope unit
`timescale 1ns / 1ps

package adsr_pkg;

  // level format: unsigned q1.16, full scale is 1.0
  localparam int LEVEL_FRAC_BITS = 16;
  localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
  localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(1) << LEVEL_FRAC_BITS;

  // divide loop produces one quotient bit per step
  localparam int DIV_CNT_W = $clog2(LEVEL_W);

  localparam int CFG_IDX_W = 3;

  typedef struct packed {
    logic note_on;
    logic key_up;
    logic tick;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               finished;
  } out_word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PREATTACK   = 3'd0,
    REG_SUSTAIN     = 3'd1,
    REG_ATTACK_LEN  = 3'd2,
    REG_DECAY_LEN   = 3'd3,
    REG_RELEASE_LEN = 3'd4
  } cfg_reg_t;

  // datapath operation of one microcode step
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_EVENTS,
    OP_PREP,
    OP_SELECT,
    OP_MUL,
    OP_DIV,
    OP_UPDATE,
    OP_EMIT
  } op_t;

  // jump condition: taken jumps to target, otherwise step + 1
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NOT_ACCEPT,
    COND_NO_TICK,
    COND_FINISHED,
    COND_NO_DIV,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_WAIT   = 3'd0;
  localparam step_t STEP_EVENTS = 3'd1;
  localparam step_t STEP_PREP   = 3'd2;
  localparam step_t STEP_SELECT = 3'd3;
  localparam step_t STEP_MUL    = 3'd4;
  localparam step_t STEP_DIV    = 3'd5;
  localparam step_t STEP_UPDATE = 3'd6;
  localparam step_t STEP_EMIT   = 3'd7;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // status the datapath reports for jump decisions
  typedef struct packed {
    logic in_accept;
    logic tick;
    logic finished;
    logic need_div;
    logic div_more;
    logic out_busy;
  } dp_status_t;

  // control store; the last step falls through by wrapping to the wait step
  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t w;
    case (step)
      STEP_WAIT:   w = '{op: OP_WAIT,   cond: COND_NOT_ACCEPT, target: STEP_WAIT};
      STEP_EVENTS: w = '{op: OP_EVENTS, cond: COND_NO_TICK,    target: STEP_WAIT};
      STEP_PREP:   w = '{op: OP_PREP,   cond: COND_FINISHED,   target: STEP_EMIT};
      STEP_SELECT: w = '{op: OP_SELECT, cond: COND_NO_DIV,     target: STEP_EMIT};
      STEP_MUL:    w = '{op: OP_MUL,    cond: COND_NEVER,      target: STEP_WAIT};
      STEP_DIV:    w = '{op: OP_DIV,    cond: COND_DIV_MORE,   target: STEP_DIV};
      STEP_UPDATE: w = '{op: OP_UPDATE, cond: COND_NEVER,      target: STEP_WAIT};
      STEP_EMIT:   w = '{op: OP_EMIT,   cond: COND_OUT_BUSY,   target: STEP_EMIT};
      default:     w = '{op: OP_WAIT,   cond: COND_NEVER,      target: STEP_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] v);
    return (v > FULL_SCALE) ? FULL_SCALE : v;
  endfunction

endpackage

/* rtl/adsr_seq.sv */
// microcode sequencer: step counter, control store lookup and jump logic
`timescale 1ns / 1ps

module adsr_seq
  import adsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t status,
  output ctrl_word_t ctrl
);

  step_t step;
  step_t step_next;
  logic  take;

  assign ctrl = ucode(step);

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:      take = 1'b0;
      COND_NOT_ACCEPT: take = !status.in_accept;
      COND_NO_TICK:    take = !status.tick;
      COND_FINISHED:   take = status.finished;
      COND_NO_DIV:     take = !status.need_div;
      COND_DIV_MORE:   take = status.div_more;
      COND_OUT_BUSY:   take = status.out_busy;
      default:         take = 1'b0;
    endcase
    step_next = take ? ctrl.target : step + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

/* rtl/adsr_datapath.sv */
// envelope state, multiply and shift-subtract divide datapath, word registers
`timescale 1ns / 1ps

module adsr_datapath
  import adsr_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_word_t             ctrl,
  output dp_status_t             status,
  input  logic [LEVEL_W-1:0]     pre_level,
  input  logic [LEVEL_W-1:0]     sus_level,
  input  logic [LENGTH_BITS-1:0] attack_len,
  input  logic [LENGTH_BITS-1:0] decay_len,
  input  logic [LENGTH_BITS-1:0] release_len,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_data
);

  localparam int POS_W  = LENGTH_BITS + 1;
  localparam int PROD_W = LEVEL_W + LENGTH_BITS;

  in_word_t             item;
  logic [LEVEL_W-1:0]   amplitude;
  logic [LEVEL_W-1:0]   work_sustain;
  logic                 in_attack;
  logic                 in_release;
  logic                 is_finished;
  logic [POS_W-1:0]     attack_pos;
  logic [POS_W-1:0]     release_pos;
  logic [LEVEL_W-1:0]   prior_level;

  logic [LEVEL_W-1:0]     mul_x;
  logic [LENGTH_BITS-1:0] mul_m;
  logic [LENGTH_BITS-1:0] divisor;
  logic [LEVEL_W-1:0]     base;
  logic                   negate;
  logic [LENGTH_BITS-1:0] rem;
  logic [LEVEL_W-1:0]     quo;
  logic [DIV_CNT_W-1:0]   div_count;

  logic [LEVEL_W-1:0]   pre_sat;
  logic [POS_W-1:0]     attack_ext;
  logic [POS_W-1:0]     ad_sum;
  logic [POS_W-1:0]     decay_pos;
  logic                 in_ramp;
  logic                 in_decay;
  logic                 in_fade;
  logic [PROD_W-1:0]    product;
  logic [LENGTH_BITS:0] trial;
  logic [LENGTH_BITS:0] trial_diff;
  logic                 qbit;
  logic                 accept;
  logic                 out_busy;
  logic                 emit_now;

  assign in_ready = (ctrl.op == OP_WAIT);
  assign accept   = in_valid && in_ready;
  assign out_busy = out_valid && !out_ready;
  assign emit_now = (ctrl.op == OP_EMIT) && !out_busy;

  // phase decision on the state left by the prep step
  assign pre_sat    = sat_level(pre_level);
  assign attack_ext = {1'b0, attack_len};
  assign ad_sum     = attack_ext + {1'b0, decay_len};
  assign decay_pos  = attack_pos - attack_ext;
  assign in_ramp    = in_attack && (attack_pos < attack_ext);
  assign in_decay   = in_attack && !in_ramp && (attack_pos < ad_sum);
  assign in_fade    = !in_attack && in_release && (release_pos < {1'b0, release_len});

  assign product    = PROD_W'(mul_x) * PROD_W'(mul_m);

  // one restoring divide step
  assign trial      = {rem, quo[LEVEL_W-1]};
  assign trial_diff = trial - {1'b0, divisor};
  assign qbit       = (trial >= {1'b0, divisor});

  assign status = '{
    in_accept: accept,
    tick:      item.tick,
    finished:  is_finished,
    need_div:  in_ramp || in_decay || in_fade,
    div_more:  (div_count != '0),
    out_busy:  out_busy
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude    <= '0;
      work_sustain <= '0;
      in_attack    <= 1'b1;
      in_release   <= 1'b0;
      is_finished  <= 1'b0;
      attack_pos   <= '0;
      release_pos  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (ctrl.op)
        OP_WAIT: begin
          if (accept) begin
            item <= in_data;
          end
        end
        OP_EVENTS: begin
          if (item.note_on) begin
            amplitude    <= pre_sat;
            work_sustain <= sat_level(sus_level);
            in_attack    <= 1'b1;
            in_release   <= item.key_up;
            is_finished  <= 1'b0;
            attack_pos   <= '0;
            release_pos  <= '0;
          end else if (item.key_up) begin
            in_release <= 1'b1;
          end
        end
        OP_PREP: begin
          prior_level <= is_finished ? '0 : amplitude;
          if (!is_finished && in_attack && in_release) begin
            work_sustain <= amplitude;
            in_attack    <= 1'b0;
          end
        end
        OP_SELECT: begin
          if (in_attack) begin
            if (in_ramp) begin
              mul_x   <= FULL_SCALE - pre_sat;
              mul_m   <= attack_pos[LENGTH_BITS-1:0];
              divisor <= attack_len;
              base    <= pre_sat;
              negate  <= 1'b0;
            end else if (in_decay) begin
              mul_x   <= FULL_SCALE - work_sustain;
              mul_m   <= decay_pos[LENGTH_BITS-1:0];
              divisor <= decay_len;
              base    <= FULL_SCALE;
              negate  <= 1'b1;
            end else begin
              in_attack <= 1'b0;
            end
            if (attack_pos != '1) begin
              attack_pos <= attack_pos + POS_W'(1);
            end
          end else if (in_release) begin
            if (in_fade) begin
              mul_x   <= work_sustain;
              mul_m   <= release_len - release_pos[LENGTH_BITS-1:0];
              divisor <= release_len;
              base    <= '0;
              negate  <= 1'b0;
            end else begin
              is_finished <= 1'b1;
            end
            if (release_pos != '1) begin
              release_pos <= release_pos + POS_W'(1);
            end
          end
        end
        OP_MUL: begin
          rem       <= product[PROD_W-1:LEVEL_W];
          quo       <= product[LEVEL_W-1:0];
          div_count <= DIV_CNT_W'(LEVEL_W - 1);
        end
        OP_DIV: begin
          rem       <= qbit ? trial_diff[LENGTH_BITS-1:0] : trial[LENGTH_BITS-1:0];
          quo       <= {quo[LEVEL_W-2:0], qbit};
          div_count <= div_count - DIV_CNT_W'(1);
        end
        OP_UPDATE: begin
          amplitude <= negate ? base - quo : base + quo;
        end
        OP_EMIT: begin
          if (emit_now) begin
            out_data.level    <= prior_level;
            out_data.finished <= is_finished;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/linear_adsr_envelope_unit.sv */
// top level of the linear adsr envelope unit: register file, sequencer and datapath
`timescale 1ns / 1ps

// Linear ADSR envelope for one voice. Each input word may restart the note
// (note_on), mark the key released (key_up) and advance one sample (tick);
// a tick returns one output word with the level held before the tick (zero
// once finished) and the finished flag after it. Levels are unsigned Q1.16.
// While the envelope ramps, a word with tick set goes from wait through
// three control steps (events, prep, select), one multiply, 17 restoring
// divide steps by the phase length at one quotient bit each, update and
// emit; a tick needing no ramp skips from select to emit, a tick once
// finished from prep to emit, and a word without tick returns to wait after
// events. An output register holds the finished word, so the next word can
// be accepted while it waits; the emit step stalls only if the previous
// word is still untaken. New sustain levels apply from the next note_on;
// pre-attack levels and lengths are read live. Configuration writes are
// taken at any time and should only be made while the unit is idle.
module linear_adsr_envelope_unit
  import adsr_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [((LENGTH_BITS > LEVEL_W) ? LENGTH_BITS : LEVEL_W)-1:0] cfg_data,
  // input words
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  // output words
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data
);

  // configuration registers
  logic [LEVEL_W-1:0]     preattack_level;
  logic [LEVEL_W-1:0]     sustain_level;
  logic [LENGTH_BITS-1:0] attack_length;
  logic [LENGTH_BITS-1:0] decay_length;
  logic [LENGTH_BITS-1:0] release_length;

  ctrl_word_t ctrl;
  dp_status_t status;

  // writes never stall
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      preattack_level <= '0;
      sustain_level   <= '0;
      attack_length   <= '0;
      decay_length    <= '0;
      release_length  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PREATTACK:   preattack_level <= cfg_data[LEVEL_W-1:0];
        REG_SUSTAIN:     sustain_level   <= cfg_data[LEVEL_W-1:0];
        REG_ATTACK_LEN:  attack_length   <= cfg_data[LENGTH_BITS-1:0];
        REG_DECAY_LEN:   decay_length    <= cfg_data[LENGTH_BITS-1:0];
        REG_RELEASE_LEN: release_length  <= cfg_data[LENGTH_BITS-1:0];
        // unused indexes are dropped
        default: begin
        end
      endcase
    end
  end

  // step counter walking the control store
  adsr_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // envelope state and arithmetic
  adsr_datapath #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .status      (status),
    .pre_level   (preattack_level),
    .sus_level   (sustain_level),
    .attack_len  (attack_length),
    .decay_len   (decay_length),
    .release_len (release_length),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

/* rtl/adsr_checker.sv */
// port-level checks of the linear adsr envelope unit and their bind
`timescale 1ns / 1ps

module adsr_checker
  import adsr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // a pending output word is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // a level never exceeds full scale
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.level <= FULL_SCALE))
    else $error("level above full scale");

  // one word at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // a word without tick only latches events and frees the input quickly
  a_no_tick_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data.tick |-> ##2 in_ready)
    else $error("word without tick held the input too long");

endmodule

bind linear_adsr_envelope_unit adsr_checker u_adsr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
